// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the 2D vector rotate and angle unit.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define VRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define VRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/vra_pkg.sv -----
// Package for the 2D vector rotate and angle unit: widths, angle constants,
// the arctangent table and the structs passed between pipeline sections.
// Depends on nothing.
package vra_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int FRAC_BITS    = 16;
  localparam int PRE_SHIFT    = 29;
  localparam int ZW           = 36;
  localparam int VW           = 64;
  localparam int RW           = 33 + FRAC_BITS + 3;
  localparam int AW           = 25;
  localparam int TW           = 26;

  localparam logic signed [ZW-1:0] Z_FULL  = 36'sd6039797760;
  localparam logic signed [ZW-1:0] Z_HALF  = 36'sd3019898880;
  localparam logic signed [ZW-1:0] Z_QUART = 36'sd1509949440;

  localparam logic [AW-1:0] DEG360 = 25'd23592960;
  localparam logic [AW-1:0] DEG180 = 25'd11796480;
  localparam logic [AW-1:0] DEG90  = 25'd5898240;

  localparam logic signed [32:0] GAIN_S = 33'sd2608131496;

  typedef enum logic [1:0] {
    OP_ROTATE = 2'd0,
    OP_ANGLE  = 2'd1,
    OP_FULL   = 2'd2,
    OP_PROJ   = 2'd3
  } op_t;

  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
    30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
    30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671, 30'd29335,
    30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229,
    30'd115, 30'd57, 30'd29, 30'd14, 30'd7, 30'd4, 30'd2, 30'd1, 30'd0
  };

  function automatic logic signed [ZW-1:0] atan_at(input int idx);
    return $signed({{(ZW-30){1'b0}}, ATAN_TAB[idx]});
  endfunction

  typedef struct packed {
    op_t                     op;
    logic                    deg;
    logic                    cs_zero;
    logic                    cs_neg;
    logic                    ds_zero;
    logic                    ds_pos;
    logic signed [31:0]      ax;
    logic signed [31:0]      ay;
    logic signed [ZW-1:0]    rang;
  } side_t;

  typedef struct packed {
    op_t                     op;
    logic                    deg;
    logic                    ds_zero;
    logic [AW-1:0]           angle;
  } tail_t;

  typedef struct packed {
    logic signed [VW-1:0]    x;
    logic signed [VW-1:0]    y;
    logic signed [ZW-1:0]    z;
  } vec_t;

  typedef struct packed {
    logic signed [RW-1:0]    x;
    logic signed [RW-1:0]    y;
    logic signed [ZW-1:0]    z;
  } rvec_t;

endpackage

// ----- rtl/vector2d_rotate_angle_unit.sv -----
// Top level of the 2D vector rotate and angle unit. Every item passes a
// pipeline of 2*CORDIC_STEPS+8 register stages (56 at 24 steps): two front
// stages, the heading CORDIC, five angle and gain stages, the rotation CORDIC
// and the output register. One item enters per cycle; while a result waits at
// the output the whole pipeline holds and in_tready is low.
`include "assert_macros.svh"

module vector2d_rotate_angle_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,   // ax[31:0], ay[63:32], bx[95:64], by[127:96], turn[153:128]
  input  logic [1:0]   in_tuser,   // opcode[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // out_x[31:0], out_y[63:32], out_angle[88:64],
                                   // out_length[120:89]
  output logic [0:0]   out_tuser   // degenerate[0]
);
  import vra_pkg::*;

  logic                 adv;
  logic                 f_valid, h_valid, p_valid, r_valid;
  side_t                f_side, h_side;
  vec_t                 f_va, f_vb;
  logic signed [ZW-1:0] h_za, h_zb;
  tail_t                p_tail, r_tail;
  rvec_t                p_rv, r_rv;
  logic signed [31:0]   rx, ry;
  logic                 out_valid_r;
  logic [127:0]         out_data_r, out_data_nxt;
  logic                 out_deg_r;

  localparam logic signed [RW-1:0] SAT_HI = {{(RW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = {{(RW-31){1'b1}}, {31{1'b0}}};

  function automatic logic signed [31:0] round_sat(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] s;
    s = (v + (RW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (s > SAT_HI) begin
      return SAT_HI[31:0];
    end else if (s < SAT_LO) begin
      return SAT_LO[31:0];
    end
    return s[31:0];
  endfunction

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  vra_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_tvalid),
    .op        (op_t'(in_tuser)),
    .ax        ($signed(in_tdata[31:0])),
    .ay        ($signed(in_tdata[63:32])),
    .bx        ($signed(in_tdata[95:64])),
    .by        ($signed(in_tdata[127:96])),
    .turn      ($signed(in_tdata[153:128])),
    .out_valid (f_valid),
    .side      (f_side),
    .va        (f_va),
    .vb        (f_vb)
  );

  vra_vec_pipe u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (f_valid),
    .side_in   (f_side),
    .va_in     (f_va),
    .vb_in     (f_vb),
    .out_valid (h_valid),
    .side_out  (h_side),
    .za        (h_za),
    .zb        (h_zb)
  );

  vra_angle_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (h_valid),
    .side_in   (h_side),
    .za        (h_za),
    .zb        (h_zb),
    .out_valid (p_valid),
    .tail_out  (p_tail),
    .rv_out    (p_rv)
  );

  vra_rot_pipe u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (p_valid),
    .tail_in   (p_tail),
    .rv_in     (p_rv),
    .out_valid (r_valid),
    .tail_out  (r_tail),
    .rv_out    (r_rv)
  );

  assign rx = round_sat(r_rv.x);
  assign ry = round_sat(r_rv.y);

  always_comb begin
    out_data_nxt          = '0;
    out_data_nxt[88:64]   = r_tail.angle;
    if (r_tail.op == OP_ROTATE) begin
      out_data_nxt[31:0]  = rx;
      out_data_nxt[63:32] = ry;
    end
    if ((r_tail.op == OP_PROJ) && !r_tail.deg && !r_tail.ds_zero) begin
      out_data_nxt[120:89] = rx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_deg_r  <= r_tail.deg;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_deg_r;

  `VRA_ASSERT_IMP(a_deg_no_rotate, out_tvalid && out_tuser[0], out_tdata[63:0] == 64'd0, "degenerate item carries a rotated vector")
  `VRA_ASSERT_IMP(a_angle_range, out_tvalid, out_tdata[88:64] <= DEG360, "angle beyond a full turn")
  `VRA_ASSERT_IMP(a_len_alone, out_tvalid && (out_tdata[120:89] != 32'd0), out_tdata[88:0] == 89'd0, "projection item carries other results")

endmodule

// ----- rtl/vra_front.sv -----
// Front section: cross and dot products, zero-vector detection, reduction of
// the rotation angle and setup of both heading vectors. Uses vra_pkg.
module vra_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  vra_pkg::op_t        op,
  input  logic signed [31:0]  ax,
  input  logic signed [31:0]  ay,
  input  logic signed [31:0]  bx,
  input  logic signed [31:0]  by,
  input  logic signed [25:0]  turn,
  output logic                out_valid,
  output vra_pkg::side_t      side,
  output vra_pkg::vec_t       va,
  output vra_pkg::vec_t       vb
);
  import vra_pkg::*;

  logic                 v1_r, v2_r;
  op_t                  op1_r;
  logic signed [31:0]   ax1_r, ay1_r;
  logic                 deg1_r;
  logic signed [63:0]   pcx_r, pcy_r, pdx_r, pdy_r;
  logic signed [ZW-1:0] raw1_r, raw1_nxt;
  vec_t                 va1_r, vb1_r, va2_r, vb2_r;
  side_t                side2_r, side2_nxt;
  logic                 deg1_nxt;
  logic signed [63:0]   neg_dy;

  function automatic vec_t head_init(input logic signed [31:0] x, input logic signed [31:0] y);
    vec_t r;
    r.x = VW'(x) <<< PRE_SHIFT;
    r.y = VW'(y) <<< PRE_SHIFT;
    r.z = '0;
    if (x[31]) begin
      r.x = -r.x;
      r.y = -r.y;
      r.z = Z_HALF;
    end
    return r;
  endfunction

  assign raw1_nxt = -(ZW'(turn) <<< 8);
  assign deg1_nxt = (op != OP_ROTATE) &&
                    (((ax == 32'sd0) && (ay == 32'sd0)) || ((bx == 32'sd0) && (by == 32'sd0)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r  <= op;
      ax1_r  <= ax;
      ay1_r  <= ay;
      deg1_r <= deg1_nxt;
      pcx_r  <= ax * by;
      pcy_r  <= ay * bx;
      pdx_r  <= ax * bx;
      pdy_r  <= ay * by;
      raw1_r <= raw1_nxt;
      va1_r  <= head_init(ax, ay);
      vb1_r  <= head_init(bx, by);
    end
  end

  assign neg_dy = -pdy_r;

  always_comb begin
    side2_nxt.op      = op1_r;
    side2_nxt.deg     = deg1_r;
    side2_nxt.cs_zero = (pcx_r == pcy_r);
    side2_nxt.cs_neg  = (pcx_r < pcy_r);
    side2_nxt.ds_zero = (pdx_r == neg_dy);
    side2_nxt.ds_pos  = (pdx_r > neg_dy);
    side2_nxt.ax      = ax1_r;
    side2_nxt.ay      = ay1_r;
    if (raw1_r >= Z_FULL) begin
      side2_nxt.rang = raw1_r - Z_FULL;
    end else if (raw1_r <= -Z_FULL) begin
      side2_nxt.rang = raw1_r + Z_FULL;
    end else begin
      side2_nxt.rang = raw1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r <= side2_nxt;
      va2_r   <= va1_r;
      vb2_r   <= vb1_r;
    end
  end

  assign out_valid = v2_r;
  assign side      = side2_r;
  assign va        = va2_r;
  assign vb        = vb2_r;

endmodule

// ----- rtl/vra_vec_pipe.sv -----
// Vectoring CORDIC pipeline that turns both input vectors onto the x axis,
// one iteration per stage, accumulating their headings. Uses vra_pkg.
module vra_vec_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  vra_pkg::side_t             side_in,
  input  vra_pkg::vec_t              va_in,
  input  vra_pkg::vec_t              vb_in,
  output logic                       out_valid,
  output vra_pkg::side_t             side_out,
  output logic signed [vra_pkg::ZW-1:0] za,
  output logic signed [vra_pkg::ZW-1:0] zb
);
  import vra_pkg::*;

  logic  vld_r  [CORDIC_STEPS];
  side_t side_r [CORDIC_STEPS];
  vec_t  a_r    [CORDIC_STEPS];
  vec_t  b_r    [CORDIC_STEPS];

  function automatic vec_t vec_step(input vec_t v, input int i);
    vec_t r;
    logic signed [VW-1:0] dx, dy;
    dx = v.y >>> i;
    dy = v.x >>> i;
    if (v.y[VW-1]) begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - atan_at(i);
    end else begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + atan_at(i);
    end
    return r;
  endfunction

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_st
    logic  v_in;
    side_t s_in;
    vec_t  a_in, b_in;
    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign s_in = side_in;
      assign a_in = va_in;
      assign b_in = vb_in;
    end else begin : g_next
      assign v_in = vld_r[i-1];
      assign s_in = side_r[i-1];
      assign a_in = a_r[i-1];
      assign b_in = b_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i] <= s_in;
        a_r[i]    <= vec_step(a_in, i);
        b_r[i]    <= vec_step(b_in, i);
      end
    end
  end

  assign out_valid = vld_r[CORDIC_STEPS-1];
  assign side_out  = side_r[CORDIC_STEPS-1];
  assign za        = a_r[CORDIC_STEPS-1].z;
  assign zb        = b_r[CORDIC_STEPS-1].z;

endmodule

// ----- rtl/vra_angle_prep.sv -----
// Angle section: wraps the headings, forms the angle result, reduces and folds
// the rotation angle and applies the CORDIC gain to vector a. Uses vra_pkg.
module vra_angle_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  vra_pkg::side_t                side_in,
  input  logic signed [vra_pkg::ZW-1:0] za,
  input  logic signed [vra_pkg::ZW-1:0] zb,
  output logic                          out_valid,
  output vra_pkg::tail_t                tail_out,
  output vra_pkg::rvec_t                rv_out
);
  import vra_pkg::*;

  logic                 v1_r, v2_r, v3_r, v4_r, v5_r;
  side_t                s1_r, s2_r, s3_r;
  logic signed [ZW-1:0] ha1_r, hb1_r;
  logic signed [ZW-1:0] d2_r, d2_nxt, sang2_r, sang2_nxt;
  logic signed [ZW-1:0] dsum, dshift;
  logic [AW-1:0]        dr3_r, dr3_nxt;
  logic signed [ZW-1:0] sang3_r, sang3_nxt;
  logic [AW-1:0]        half_ang, sel_ang;
  tail_t                t4_r, t4_nxt, t5_r;
  logic signed [ZW-1:0] sang4_r, sang4_nxt;
  logic signed [32:0]   qx4_r, qy4_r, qx4_nxt, qy4_nxt;
  logic signed [65:0]   px, py;
  rvec_t                rv5_r;

  function automatic logic signed [ZW-1:0] wrap_head(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] z1;
    z1 = z[ZW-1] ? z + Z_FULL : z;
    return (z1 >= Z_FULL) ? z1 - Z_FULL : z1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_comb begin
    d2_nxt = hb1_r - ha1_r;
    if (d2_nxt[ZW-1]) begin
      d2_nxt = d2_nxt + Z_FULL;
    end
    sang2_nxt = (s1_r.op == OP_ROTATE) ? s1_r.rang : -hb1_r;
  end

  assign dsum   = d2_r + ZW'(128);
  assign dshift = dsum >>> 8;

  always_comb begin
    dr3_nxt = dshift[AW-1:0];
    if (dr3_nxt >= DEG360) begin
      dr3_nxt = dr3_nxt - DEG360;
    end
    if (sang2_r > Z_HALF) begin
      sang3_nxt = sang2_r - Z_FULL;
    end else if (sang2_r <= -Z_HALF) begin
      sang3_nxt = sang2_r + Z_FULL;
    end else begin
      sang3_nxt = sang2_r;
    end
  end

  always_comb begin
    half_ang = (dr3_r <= DEG180) ? dr3_r : DEG360 - dr3_r;
    if (s3_r.cs_zero) begin
      sel_ang = s3_r.ds_pos ? '0 : DEG180;
    end else if (s3_r.ds_zero) begin
      sel_ang = DEG90;
    end else begin
      sel_ang = half_ang;
    end
    if ((s3_r.op == OP_FULL) && s3_r.cs_neg) begin
      sel_ang = DEG360 - sel_ang;
    end
    t4_nxt.op      = s3_r.op;
    t4_nxt.deg     = s3_r.deg;
    t4_nxt.ds_zero = s3_r.ds_zero;
    t4_nxt.angle   = (((s3_r.op == OP_ANGLE) || (s3_r.op == OP_FULL)) && !s3_r.deg) ?
                     sel_ang : '0;
    qx4_nxt = 33'(s3_r.ax);
    qy4_nxt = 33'(s3_r.ay);
    if (sang3_r > Z_QUART) begin
      sang4_nxt = sang3_r - Z_HALF;
      qx4_nxt   = -qx4_nxt;
      qy4_nxt   = -qy4_nxt;
    end else if (sang3_r < -Z_QUART) begin
      sang4_nxt = sang3_r + Z_HALF;
      qx4_nxt   = -qx4_nxt;
      qy4_nxt   = -qy4_nxt;
    end else begin
      sang4_nxt = sang3_r;
    end
  end

  assign px = qx4_r * GAIN_S;
  assign py = qy4_r * GAIN_S;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r    <= side_in;
      ha1_r   <= wrap_head(za);
      hb1_r   <= wrap_head(zb);
      s2_r    <= s1_r;
      d2_r    <= d2_nxt;
      sang2_r <= sang2_nxt;
      s3_r    <= s2_r;
      dr3_r   <= dr3_nxt;
      sang3_r <= sang3_nxt;
      t4_r    <= t4_nxt;
      sang4_r <= sang4_nxt;
      qx4_r   <= qx4_nxt;
      qy4_r   <= qy4_nxt;
      t5_r    <= t4_r;
      rv5_r.x <= RW'(px >>> (32 - FRAC_BITS));
      rv5_r.y <= RW'(py >>> (32 - FRAC_BITS));
      rv5_r.z <= sang4_r;
    end
  end

  assign out_valid = v5_r;
  assign tail_out  = t5_r;
  assign rv_out    = rv5_r;

endmodule

// ----- rtl/vra_rot_pipe.sv -----
// Rotation CORDIC pipeline that turns the gain-scaled vector a by the prepared
// angle, one iteration per stage. Uses vra_pkg.
module vra_rot_pipe (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  vra_pkg::tail_t tail_in,
  input  vra_pkg::rvec_t rv_in,
  output logic           out_valid,
  output vra_pkg::tail_t tail_out,
  output vra_pkg::rvec_t rv_out
);
  import vra_pkg::*;

  logic  vld_r  [CORDIC_STEPS];
  tail_t tail_r [CORDIC_STEPS];
  rvec_t v_r    [CORDIC_STEPS];

  function automatic rvec_t rot_step(input rvec_t v, input int i);
    rvec_t r;
    logic signed [RW-1:0] dx, dy;
    dx = v.y >>> i;
    dy = v.x >>> i;
    if (!v.z[ZW-1]) begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - atan_at(i);
    end else begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + atan_at(i);
    end
    return r;
  endfunction

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_st
    logic  v_in;
    tail_t t_in;
    rvec_t r_in;
    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign t_in = tail_in;
      assign r_in = rv_in;
    end else begin : g_next
      assign v_in = vld_r[i-1];
      assign t_in = tail_r[i-1];
      assign r_in = v_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tail_r[i] <= t_in;
        v_r[i]    <= rot_step(r_in, i);
      end
    end
  end

  assign out_valid = vld_r[CORDIC_STEPS-1];
  assign tail_out  = tail_r[CORDIC_STEPS-1];
  assign rv_out    = v_r[CORDIC_STEPS-1];

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for vector2d_rotate_angle_unit: rotation, angle,
// full angle and projection items are checked against a predictor in this file.
// Depends on vra_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module tb_top;
  import vra_pkg::*;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [24:0] angle;
    logic [31:0] length;
    logic        deg;
  } vres_t;

  localparam longint GAIN = 64'sd2608131496;
  localparam longint PRE  = 64'sd536870912;
  localparam int LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [159:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [0:0]   out_tuser;

  vres_t pending_results[$];
  int    errors = 0;
  int    checked = 0;
  int    cycles = 0;
  int    op_count[4] = '{0, 0, 0, 0};
  int    degenerate_seen = 0;
  bit    calm = 1'b0;

  vector2d_rotate_angle_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint heading_of(longint qx, longint qy);
    longint base, z, dx, dy;
    base = 0;
    z = 0;
    qx = qx * PRE;
    qy = qy * PRE;
    if (qx < 0) begin
      qx = -qx;
      qy = -qy;
      base = longint'(Z_HALF);
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = qy >>> i;
      dy = qx >>> i;
      if (qy < 0) begin
        qx -= dx; qy += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        qx += dx; qy -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    z += base;
    if (z < 0) z += longint'(Z_FULL);
    if (z >= longint'(Z_FULL)) z -= longint'(Z_FULL);
    return z;
  endfunction

  task automatic turn_vector(input longint qx, input longint qy, input longint ang,
                             output longint rx, output longint ry);
    longint dx, dy, rnd;
    ang = ang % longint'(Z_FULL);
    if (ang > longint'(Z_HALF)) ang -= longint'(Z_FULL);
    else if (ang <= -longint'(Z_HALF)) ang += longint'(Z_FULL);
    if (ang > longint'(Z_QUART)) begin
      qx = -qx; qy = -qy; ang -= longint'(Z_HALF);
    end else if (ang < -longint'(Z_QUART)) begin
      qx = -qx; qy = -qy; ang += longint'(Z_HALF);
    end
    qx = (qx * GAIN) >>> (32 - FRAC_BITS);
    qy = (qy * GAIN) >>> (32 - FRAC_BITS);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = qy >>> i;
      dy = qx >>> i;
      if (ang >= 0) begin
        qx -= dx; qy += dy; ang -= longint'(ATAN_TAB[i]);
      end else begin
        qx += dx; qy -= dy; ang += longint'(ATAN_TAB[i]);
      end
    end
    rnd = longint'(1) << (FRAC_BITS - 1);
    rx = sat32((qx + rnd) >>> FRAC_BITS);
    ry = sat32((qy + rnd) >>> FRAC_BITS);
  endtask

  task automatic predict_vector_op(input op_t op, input logic signed [31:0] ax,
                                   input logic signed [31:0] ay, input logic signed [31:0] bx,
                                   input logic signed [31:0] by, input logic signed [25:0] turn,
                                   output vres_t r);
    longint a_x, a_y, b_x, b_y, rx, ry, ang, len, d, cp, cq, dp, dq;
    a_x = ax; a_y = ay; b_x = bx; b_y = by;
    rx = 0; ry = 0; ang = 0; len = 0;
    r.deg = 1'b0;
    if (op == OP_ROTATE) begin
      turn_vector(a_x, a_y, -longint'(turn) * 256, rx, ry);
    end else if ((a_x == 0 && a_y == 0) || (b_x == 0 && b_y == 0)) begin
      r.deg = 1'b1;
    end else begin
      cp = a_x * b_y;
      cq = a_y * b_x;
      dp = a_x * b_x;
      dq = -(a_y * b_y);
      if (op == OP_PROJ) begin
        if (dp != dq) turn_vector(a_x, a_y, -heading_of(b_x, b_y), len, ry);
        ry = 0;
      end else begin
        if (cp == cq) begin
          ang = (dp > dq) ? 0 : longint'(DEG180);
        end else if (dp == dq) begin
          ang = longint'(DEG90);
        end else begin
          d = heading_of(b_x, b_y) - heading_of(a_x, a_y);
          if (d < 0) d += longint'(Z_FULL);
          d = (d + 128) >>> 8;
          if (d >= longint'(DEG360)) d -= longint'(DEG360);
          ang = (d <= longint'(DEG180)) ? d : longint'(DEG360) - d;
        end
        if (op == OP_FULL && cp < cq) ang = longint'(DEG360) - ang;
      end
    end
    r.x = rx[31:0];
    r.y = ry[31:0];
    r.angle = ang[24:0];
    r.length = len[31:0];
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 28);
  end

  always @(posedge clk) begin
    vres_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no item outstanding: %h", $time, out_tdata);
      end else begin
        e = pending_results.pop_front();
        checked++;
        if (out_tdata[31:0] !== e.x || out_tdata[63:32] !== e.y ||
            out_tdata[88:64] !== e.angle || out_tdata[120:89] !== e.length ||
            out_tuser[0] !== e.deg) begin
          errors++;
          $display("%0t: mismatch exp x=%h y=%h a=%0d l=%h d=%b got x=%h y=%h a=%0d l=%h d=%b",
                   $time, e.x, e.y, e.angle, e.length, e.deg, out_tdata[31:0],
                   out_tdata[63:32], out_tdata[88:64], out_tdata[120:89], out_tuser[0]);
        end
      end
    end
  end

  task automatic send_item(input op_t op, input logic [31:0] ax, input logic [31:0] ay,
                           input logic [31:0] bx, input logic [31:0] by,
                           input logic [25:0] turn);
    vres_t r;
    if (!calm) begin
      while ($urandom_range(0, 99) < 28) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {6'd0, turn, by, bx, ay, ax};
    do @(posedge clk); while (!in_tready);
    predict_vector_op(op, ax, ay, bx, by, turn, r);
    pending_results.push_back(r);
    op_count[op]++;
    if (r.deg) degenerate_seen++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return $urandom_range(0, 6) - 3;
      3: return $urandom_range(0, 2097152) - 1048576;
      default: return $urandom_range(0, 33554432) - 16777216;
    endcase
  endfunction

  function automatic logic [25:0] pick_turn();
    if ($urandom_range(0, 3) == 0) return 26'($urandom);
    return 26'($urandom_range(0, 47185920) - 23592960);
  endfunction

  task automatic test_rotate_directed();
    send_item(OP_ROTATE, 32'h00010000, 32'h0, 32'h0, 32'h0, 26'd0);
    send_item(OP_ROTATE, 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h0, 26'd2949120);
    send_item(OP_ROTATE, 32'h80000000, 32'h80000000, 32'h0, 32'h0, -26'sd2949120);
    send_item(OP_ROTATE, 32'h00010000, 32'hffff0000, 32'h0, 32'h0, 26'd23592960);
    send_item(OP_ROTATE, 32'h00030000, 32'h00020000, 32'h0, 32'h0, -26'sd23592960);
    send_item(OP_ROTATE, 32'h00050000, 32'h0, 32'h0, 32'h0, 26'h1ffffff);
    send_item(OP_ROTATE, 32'h00050000, 32'h1, 32'h0, 32'h0, 26'h2000000);
    send_item(OP_ROTATE, 32'h0, 32'h0, 32'hffffffff, 32'hffffffff, 26'd11796480);
  endtask

  task automatic test_angle_directed();
    send_item(OP_ANGLE, 32'h0, 32'h0, 32'h00010000, 32'h0, 26'd0);
    send_item(OP_FULL, 32'h00010000, 32'h0, 32'h0, 32'h0, 26'd0);
    send_item(OP_ANGLE, 32'h00010000, 32'h00010000, 32'h00020000, 32'h00020000, 26'd0);
    send_item(OP_ANGLE, 32'h00010000, 32'h00010000, 32'hfffe0000, 32'hfffe0000, 26'd0);
    send_item(OP_ANGLE, 32'h00010000, 32'h0, 32'h0, 32'h00050000, 26'd0);
    send_item(OP_FULL, 32'h00010000, 32'h0, 32'h0, 32'hfffb0000, 26'd0);
    send_item(OP_FULL, 32'h00010000, 32'h0, 32'h00010000, 32'hffffff00, 26'h3ffffff);
    send_item(OP_FULL, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 26'd0);
    send_item(OP_ANGLE, 32'h80000000, 32'h1, 32'h7fffffff, 32'h1, 26'd0);
  endtask

  task automatic test_projection_directed();
    send_item(OP_PROJ, 32'h00030000, 32'h00040000, 32'h0, 32'h0, 26'd0);
    send_item(OP_PROJ, 32'h00030000, 32'h00040000, 32'h00010000, 32'h0, 26'd0);
    send_item(OP_PROJ, 32'h00030000, 32'h0, 32'h0, 32'h00070000, 26'd0);
    send_item(OP_PROJ, 32'h7fffffff, 32'h7fffffff, 32'h1, 32'h1, 26'd0);
    send_item(OP_PROJ, 32'h80000000, 32'h80000000, 32'h1, 32'h1, 26'd0);
  endtask

  task automatic test_random_mix(input int count);
    logic [31:0] ax, ay, bx, by;
    int k;
    for (int n = 0; n < count; n++) begin
      ax = pick_coord(); ay = pick_coord(); bx = pick_coord(); by = pick_coord();
      case ($urandom_range(0, 9))
        0: begin
          ax = $urandom_range(0, 32768) - 16384;
          ay = $urandom_range(0, 32768) - 16384;
          k = $urandom_range(1, 5) * ($urandom_range(0, 1) ? 1 : -1);
          bx = ax * k; by = ay * k;
        end
        1: begin
          ax = $urandom_range(0, 32768) - 16384;
          ay = $urandom_range(0, 32768) - 16384;
          k = $urandom_range(1, 5) * ($urandom_range(0, 1) ? 1 : -1);
          bx = -ay * k; by = ax * k;
        end
        2: if ($urandom_range(0, 1)) begin ax = 0; ay = 0; end else begin bx = 0; by = 0; end
        default: ;
      endcase
      send_item(op_t'($urandom_range(0, 3)), ax, ay, bx, by, pick_turn());
    end
  endtask

  task automatic test_back_to_back(input int count);
    calm = 1'b1;
    test_random_mix(count);
    calm = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_rotate_directed();
    test_angle_directed();
    test_projection_directed();
    wait_drained();
    test_random_mix(500);
    test_back_to_back(300);
    wait_drained();
    test_random_mix(528);
    wait_drained();
    repeat (80) @(posedge clk);
    $display("covered %0d rotate, %0d angle, %0d full angle, %0d projection items",
             op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("%0d results checked, %0d degenerate, %0d errors", checked,
             degenerate_seen, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
